// ===== rtl/xlsu_pkg.sv =====
// Package with the item types, opcode and width codes, and shared helpers of the logic/shift unit.
`default_nettype none

package xlsu_pkg;

    localparam int unsigned DataW = 32;

    // Opcodes.
    localparam logic [3:0] OP_TEST = 4'd0;
    localparam logic [3:0] OP_AND  = 4'd1;
    localparam logic [3:0] OP_XOR  = 4'd2;
    localparam logic [3:0] OP_OR   = 4'd3;
    localparam logic [3:0] OP_SAR  = 4'd4;
    localparam logic [3:0] OP_SHL  = 4'd5;
    localparam logic [3:0] OP_SHR  = 4'd6;
    localparam logic [3:0] OP_NOT  = 4'd7;
    localparam logic [3:0] OP_ROL  = 4'd8;
    localparam logic [3:0] OP_SHLD = 4'd9;
    localparam logic [3:0] OP_SHRD = 4'd10;

    // Operand width codes; the unused code is handled as doubleword.
    localparam logic [1:0] WIDTH_BYTE  = 2'd0;
    localparam logic [1:0] WIDTH_WORD  = 2'd1;
    localparam logic [1:0] WIDTH_DWORD = 2'd2;

    typedef struct packed {
        logic [3:0]       opcode;
        logic [1:0]       width_code;
        logic [DataW-1:0] dest_value;
        logic [DataW-1:0] src_value;
        logic [DataW-1:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             writes_dest;
        logic             zero_flag;
        logic             sign_flag;
        logic             zs_update;
        logic             carry_flag;
        logic             carry_update;
        logic             overflow_flag;
        logic             overflow_update;
    } t_out_item;

    // Request handed to the shifter: operands are already masked to the width.
    typedef struct packed {
        logic [3:0]       opcode;
        logic [1:0]       width_code;
        logic [4:0]       count;
        logic [DataW-1:0] dest;
        logic [DataW-1:0] fill;
    } t_shift_req;

    function automatic logic [DataW-1:0] width_mask(input logic [1:0] code);
        logic [DataW-1:0] m;
        unique case (code)
            WIDTH_BYTE: m = 32'h0000_00FF;
            WIDTH_WORD: m = 32'h0000_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xlsu_shift.sv =====
// Barrel shifter for sar, shl, shr, rol, shld and shrd.
`default_nettype none

module xlsu_shift (
    input  wire xlsu_pkg::t_shift_req i_req,
    output logic [xlsu_pkg::DataW-1:0] o_result
);

    logic [31:0] w_sext;
    logic [31:0] w_sar;
    logic [31:0] w_shl;
    logic [31:0] w_shr;
    logic [31:0] w_low;
    logic [4:0]  w_lamt;
    logic [63:0] w_lcat;
    logic [63:0] w_lsh;
    logic [31:0] w_lres;
    logic [63:0] w_rcat;
    logic [63:0] w_rsh;
    logic        w_rol;

    assign w_rol = (i_req.opcode == xlsu_pkg::OP_ROL);

    // Rotate uses {dest, dest}; shld uses {dest, fill}. Both take the upper half.
    assign w_low = w_rol ? i_req.dest : i_req.fill;

    always_comb begin
        unique case (i_req.width_code)
            xlsu_pkg::WIDTH_BYTE: begin
                w_sext = {{24{i_req.dest[7]}}, i_req.dest[7:0]};
                w_lamt = w_rol ? {2'b00, i_req.count[2:0]} : i_req.count;
                w_lcat = {48'd0, i_req.dest[7:0], w_low[7:0]};
                w_rcat = {48'd0, i_req.fill[7:0], i_req.dest[7:0]};
            end
            xlsu_pkg::WIDTH_WORD: begin
                w_sext = {{16{i_req.dest[15]}}, i_req.dest[15:0]};
                w_lamt = w_rol ? {1'b0, i_req.count[3:0]} : i_req.count;
                w_lcat = {32'd0, i_req.dest[15:0], w_low[15:0]};
                w_rcat = {32'd0, i_req.fill[15:0], i_req.dest[15:0]};
            end
            default: begin
                w_sext = i_req.dest;
                w_lamt = i_req.count;
                w_lcat = {i_req.dest, w_low};
                w_rcat = {i_req.fill, i_req.dest};
            end
        endcase
    end

    assign w_sar = 32'($signed(w_sext) >>> i_req.count);
    assign w_shl = i_req.dest << i_req.count;
    assign w_shr = i_req.dest >> i_req.count;
    assign w_lsh = w_lcat << w_lamt;
    assign w_rsh = w_rcat >> i_req.count;

    always_comb begin
        unique case (i_req.width_code)
            xlsu_pkg::WIDTH_BYTE: w_lres = w_lsh[39:8];
            xlsu_pkg::WIDTH_WORD: w_lres = w_lsh[47:16];
            default:              w_lres = w_lsh[63:32];
        endcase
    end

    always_comb begin
        unique case (i_req.opcode)
            xlsu_pkg::OP_SAR:  o_result = w_sar;
            xlsu_pkg::OP_SHL:  o_result = w_shl;
            xlsu_pkg::OP_SHR:  o_result = w_shr;
            xlsu_pkg::OP_ROL,
            xlsu_pkg::OP_SHLD: o_result = w_lres;
            xlsu_pkg::OP_SHRD: o_result = w_rsh[31:0];
            default:           o_result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/xlsu_alu.sv =====
// Opcode decode, logic operations and flag generation of the logic/shift unit.
`default_nettype none

module xlsu_alu (
    input  wire xlsu_pkg::t_in_item  i_item,
    output xlsu_pkg::t_out_item      o_item
);

    logic [31:0]          w_mask;
    logic [31:0]          w_dest;
    logic [31:0]          w_fill;
    logic [31:0]          w_sh_res;
    logic [31:0]          w_raw;
    logic [31:0]          w_res;
    logic                 w_wr;
    logic                 w_zs;
    logic                 w_cu;
    logic                 w_ou;
    logic                 w_top;
    xlsu_pkg::t_shift_req w_req;

    assign w_mask = xlsu_pkg::width_mask(i_item.width_code);
    assign w_dest = i_item.dest_value & w_mask;
    assign w_fill = i_item.second_value & w_mask;

    assign w_req.opcode     = i_item.opcode;
    assign w_req.width_code = i_item.width_code;
    assign w_req.count      = i_item.src_value[4:0];
    assign w_req.dest       = w_dest;
    assign w_req.fill       = w_fill;

    xlsu_shift u_shift (
        .i_req    (w_req),
        .o_result (w_sh_res)
    );

    always_comb begin
        w_raw = '0;
        w_wr  = 1'b0;
        w_zs  = 1'b0;
        w_cu  = 1'b0;
        w_ou  = 1'b0;
        unique case (i_item.opcode)
            xlsu_pkg::OP_TEST: begin
                w_raw = w_dest & i_item.src_value;
                w_zs = 1'b1; w_cu = 1'b1; w_ou = 1'b1;
            end
            xlsu_pkg::OP_AND: begin
                w_raw = w_dest & i_item.src_value;
                w_wr = 1'b1; w_zs = 1'b1; w_cu = 1'b1; w_ou = 1'b1;
            end
            xlsu_pkg::OP_XOR: begin
                w_raw = w_dest ^ i_item.src_value;
                w_wr = 1'b1; w_zs = 1'b1; w_cu = 1'b1; w_ou = 1'b1;
            end
            xlsu_pkg::OP_OR: begin
                w_raw = w_dest | i_item.src_value;
                w_wr = 1'b1; w_zs = 1'b1; w_cu = 1'b1; w_ou = 1'b1;
            end
            xlsu_pkg::OP_SAR, xlsu_pkg::OP_SHL, xlsu_pkg::OP_SHR,
            xlsu_pkg::OP_SHLD, xlsu_pkg::OP_SHRD: begin
                w_raw = w_sh_res;
                w_wr = 1'b1; w_zs = 1'b1;
            end
            xlsu_pkg::OP_NOT: begin
                w_raw = ~w_dest;
                w_wr = 1'b1;
            end
            xlsu_pkg::OP_ROL: begin
                // A zero count leaves the carry untouched.
                w_raw = w_sh_res;
                w_wr = 1'b1;
                w_cu = (i_item.src_value[4:0] != 5'd0);
            end
            default: begin
                w_raw = '0;
            end
        endcase
    end

    assign w_res = w_raw & w_mask;

    always_comb begin
        unique case (i_item.width_code)
            xlsu_pkg::WIDTH_BYTE: w_top = w_res[7];
            xlsu_pkg::WIDTH_WORD: w_top = w_res[15];
            default:              w_top = w_res[31];
        endcase
    end

    // Only rol produces a nonzero carry; the logic operations clear it.
    assign o_item.result          = w_res;
    assign o_item.writes_dest     = w_wr;
    assign o_item.zero_flag       = w_zs & (w_res == 32'd0);
    assign o_item.sign_flag       = w_zs & w_top;
    assign o_item.zs_update       = w_zs;
    assign o_item.carry_flag      = w_cu & (i_item.opcode == xlsu_pkg::OP_ROL) & w_res[0];
    assign o_item.carry_update    = w_cu;
    assign o_item.overflow_flag   = 1'b0;
    assign o_item.overflow_update = w_ou;

endmodule

`default_nettype wire

// ===== rtl/x86_logic_shift_unit.sv =====
// Top level of the x86 logic and shift unit: input register, execute logic, result register.
`default_nettype none
// Usage:
// The input channel (i_in_valid, o_in_ready, i_in_item) carries one instruction
// per item: opcode, operand width code, destination, source or shift count,
// and the fill operand of the double shifts. The output channel (o_out_valid,
// i_out_ready, o_out_item) returns exactly one result item per input item, in
// order: the masked result, the write-back enable, and ZF, SF, CF and OF with
// their update enables.
// An item is captured in the input register at the edge it is accepted, is
// executed by one pass of decode, barrel shifter and flag logic, and lands in
// the result register once that register is empty or being emptied, where its
// result is offered until taken. While the receiver takes results, the unit
// accepts one item every cycle; that rate is set by the two register stages,
// each of which can pass on an item per cycle.
// When the receiver stalls, the result register holds its item and the input
// register fills; o_in_ready then drops until the result is taken. Ready is
// computed combinationally from i_out_ready, so no bubble is inserted when a
// stall releases.
// A synchronous active-low reset empties both stages; no item is lost or
// produced across it other than those discarded by the reset itself.

module x86_logic_shift_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire xlsu_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output xlsu_pkg::t_out_item o_out_item
);

    logic                r_s1_valid;
    logic                n_s1_valid;
    xlsu_pkg::t_in_item  r_s1_item;
    logic                r_out_valid;
    logic                n_out_valid;
    xlsu_pkg::t_out_item r_out_item;
    xlsu_pkg::t_out_item w_alu_out;

    logic w_in_fire;
    logic w_out_free;
    logic w_s1_move;

    // The result register can take a new item when empty or being emptied.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign n_s1_valid  = w_in_fire || (r_s1_valid && !w_s1_move);
    assign n_out_valid = w_s1_move || (r_out_valid && !i_out_ready);

    xlsu_alu u_alu (
        .i_item (r_s1_item),
        .o_item (w_alu_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        // Payload registers load only on a transfer and need no reset.
        if (w_in_fire) begin
            r_s1_item <= i_in_item;
        end
        if (w_s1_move) begin
            r_out_item <= w_alu_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Reset leaves the output channel empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A zero flag must agree with the result it describes.
    a_zero_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.zero_flag) |-> (o_out_item.result == 32'd0))
        else $error("zero flag set with nonzero result");

    // Flags are only reported together with their update enables.
    a_flag_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((!o_out_item.carry_flag || o_out_item.carry_update) &&
                         (!o_out_item.sign_flag || o_out_item.zs_update) &&
                         !o_out_item.overflow_flag))
        else $error("flag value without update enable");

    // A test instruction moving on reaches the output without write-back.
    a_test_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && r_s1_item.opcode == xlsu_pkg::OP_TEST) |=>
            (o_out_valid && !o_out_item.writes_dest && o_out_item.zs_update))
        else $error("test item wrote destination or was lost");

    // The input stage can only be full-and-blocked while the output waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && o_out_valid && !i_out_ready))
        else $error("input stalled without downstream backpressure");

endmodule

`default_nettype wire

// ===== test/tb_x86_logic_shift_unit.sv =====
// Self-checking testbench for the x86 logic and shift unit, with directed and random items.
`timescale 1ns / 1ps

module tb_x86_logic_shift_unit;

    import xlsu_pkg::*;

    // Opcodes 11 to 15 and width code 3 carry no operation of their own.
    localparam logic [3:0] OP_RSVD_FIRST = 4'd11;
    localparam logic [3:0] OP_RSVD_LAST  = 4'd15;
    localparam logic [1:0] WIDTH_RSVD    = 2'd3;

    localparam int unsigned PHASE_ITEMS  = 430;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 8;

    // One row of the directed table. Where typed_ok is set, the result was
    // worked out by hand and is checked as typed; otherwise the predictor
    // supplies it.
    typedef struct packed {
        t_in_item  stim;
        logic      typed_ok;
        t_out_item want;
    } t_dir_row;

    // The typed results list their fields in port order: result, writes_dest,
    // ZF, SF, ZF/SF update, CF, CF update, OF, OF update.
    localparam t_dir_row DIRECTED_ROWS [25] = '{
        // Logic operations at the extremes of their operands.
        '{'{OP_AND, WIDTH_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{OP_TEST, WIDTH_BYTE, 32'h0000_00FF, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{OP_XOR, WIDTH_WORD, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{OP_OR, WIDTH_BYTE, 32'h0000_0080, 32'hFFFF_FF00, 32'h0000_0000}, 1'b1,
          '{32'h0000_0080, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{OP_NOT, WIDTH_BYTE, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0000_00FF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_NOT, WIDTH_DWORD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        // Arithmetic shift right fills with the sign bit of the operand width.
        '{'{OP_SAR, WIDTH_BYTE, 32'h0000_0080, 32'h0000_0007, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_SAR, WIDTH_BYTE, 32'hFFFF_FF80, 32'h0000_001F, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_SAR, WIDTH_DWORD, 32'h8000_0000, 32'hFFFF_FFE0, 32'h0000_0000}, 1'b0, '0},
        // Logical shifts: a count of at least the width clears the value, and
        // only the low five bits of the count matter.
        '{'{OP_SHL, WIDTH_WORD, 32'h0000_FFFF, 32'h0000_0010, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SHL, WIDTH_DWORD, 32'h0000_0001, 32'h0000_001F, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_SHR, WIDTH_BYTE, 32'h0000_0080, 32'hFFFF_FFE7, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_SHR, WIDTH_DWORD, 32'hFFFF_FFFF, 32'h0000_0020, 32'h0000_0000}, 1'b0, '0},
        // Rotate: a zero count leaves CF alone, a count equal to the width
        // still reloads CF.
        '{'{OP_ROL, WIDTH_BYTE, 32'h0000_0081, 32'hFFFF_FFE0, 32'h0000_0000}, 1'b1,
          '{32'h0000_0081, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_ROL, WIDTH_BYTE, 32'h0000_0081, 32'h0000_0008, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_ROL, WIDTH_WORD, 32'h0000_8000, 32'h0000_0001, 32'h0000_0000}, 1'b0, '0},
        '{'{OP_ROL, WIDTH_DWORD, 32'h8000_0001, 32'h0000_001F, 32'h0000_0000}, 1'b0, '0},
        // Double shifts, including counts beyond the concatenated operands.
        '{'{OP_SHLD, WIDTH_BYTE, 32'h0000_000F, 32'h0000_0004, 32'hFFFF_FFF0}, 1'b0, '0},
        '{'{OP_SHLD, WIDTH_BYTE, 32'h0000_00FF, 32'h0000_0014, 32'h0000_00FF}, 1'b0, '0},
        '{'{OP_SHLD, WIDTH_DWORD, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{OP_SHRD, WIDTH_WORD, 32'h0000_1234, 32'h0000_000C, 32'h0000_ABCD}, 1'b0, '0},
        '{'{OP_SHRD, WIDTH_DWORD, 32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF}, 1'b0, '0},
        // Undefined opcodes produce an all-zero result.
        '{'{OP_RSVD_LAST, WIDTH_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_RSVD_FIRST, WIDTH_BYTE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        // The spare width code behaves as doubleword.
        '{'{OP_AND, WIDTH_RSVD, 32'h8765_4321, 32'hF0F0_F0F0, 32'h0000_0000}, 1'b0, '0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Percentages of cycles in which the sender holds back and the receiver
    // stalls; changed between phases of the random part.
    int unsigned send_gap_pct   = 29;
    int unsigned recv_stall_pct = 58;

    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;

    // Results owed by the unit, oldest first.
    t_out_item pending_results [$];

    x86_logic_shift_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned width_bits(input logic [1:0] code);
        int unsigned bits;
        case (code)
            WIDTH_BYTE: bits = 8;
            WIDTH_WORD: bits = 16;
            default:    bits = 32;
        endcase
        return bits;
    endfunction

    // Computes the result item of one instruction. All arithmetic runs on
    // 64-bit vectors so that the double shifts keep their full concatenation
    // and the sign extension of a doubleword survives the right shift.
    function automatic t_out_item alu_outcome(input t_in_item instr);
        t_out_item   res;
        int unsigned w;
        int unsigned rot;
        logic [63:0] msk;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] fill;
        logic [63:0] ext;
        logic [63:0] cat;
        logic [63:0] r;
        logic [4:0]  cnt;
        logic        wr;
        logic        zs_en;
        logic        cf_en;
        logic        of_en;
        logic        cf;
        res   = '0;
        w     = width_bits(instr.width_code);
        msk   = (64'd1 << w) - 64'd1;
        d     = {32'd0, instr.dest_value} & msk;
        s     = {32'd0, instr.src_value};
        fill  = {32'd0, instr.second_value} & msk;
        cnt   = instr.src_value[4:0];
        r     = '0;
        wr    = 1'b1;
        zs_en = 1'b0;
        cf_en = 1'b0;
        of_en = 1'b0;
        cf    = 1'b0;
        case (instr.opcode)
            OP_TEST, OP_AND, OP_XOR, OP_OR: begin
                if (instr.opcode == OP_XOR) begin
                    r = d ^ s;
                end else if (instr.opcode == OP_OR) begin
                    r = d | s;
                end else begin
                    r = d & s;
                end
                // Test only sets flags; it has no destination write.
                wr    = (instr.opcode != OP_TEST);
                zs_en = 1'b1;
                cf_en = 1'b1;
                of_en = 1'b1;
            end
            OP_SAR: begin
                ext = d[w-1] ? (d | ~msk) : d;
                r = ext >> cnt;
                zs_en = 1'b1;
            end
            OP_SHL: begin
                r = d << cnt;
                zs_en = 1'b1;
            end
            OP_SHR: begin
                r = d >> cnt;
                zs_en = 1'b1;
            end
            OP_NOT: begin
                r = ~d;
            end
            OP_ROL: begin
                // The rotate amount wraps at the width, but CF is loaded for
                // any nonzero count, even one that rotates all the way round.
                rot = int'(cnt) & (w - 1);
                r = d;
                if (rot != 0) begin
                    r = ((d << rot) | (d >> (w - rot))) & msk;
                end
                if (cnt != 5'd0) begin
                    cf    = r[0];
                    cf_en = 1'b1;
                end
            end
            OP_SHLD: begin
                cat = (d << w) | fill;
                r = (cat << cnt) >> w;
                zs_en = 1'b1;
            end
            OP_SHRD: begin
                cat = (fill << w) | d;
                r = cat >> cnt;
                zs_en = 1'b1;
            end
            default: begin
                wr = 1'b0;
            end
        endcase
        r = r & msk;
        res.result      = r[31:0];
        res.writes_dest = wr;
        if (zs_en) begin
            res.zero_flag = (r == 64'd0);
            res.sign_flag = r[w-1];
            res.zs_update = 1'b1;
        end
        if (cf_en) begin
            res.carry_flag   = cf;
            res.carry_update = 1'b1;
        end
        // OF is always cleared when it is updated at all.
        res.overflow_update = of_en;
        return res;
    endfunction

    // Operand with an edge pattern or random bits inside the width; the bits
    // above the width are always random so that masking gets exercised.
    function automatic logic [31:0] operand_value(input int unsigned w);
        logic [31:0] msk;
        logic [31:0] pattern;
        msk = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        case ($urandom_range(0, 7))
            0:       pattern = 32'h0000_0000;
            1:       pattern = 32'hFFFF_FFFF;
            2:       pattern = 32'd1 << (w - 1);
            3:       pattern = (32'd1 << (w - 1)) - 32'd1;
            default: pattern = $urandom;
        endcase
        return ($urandom & ~msk) | (pattern & msk);
    endfunction

    // Shift count that favors zero, one, and the counts around the width,
    // with random bits above the five that count.
    function automatic logic [31:0] shift_count(input int unsigned w);
        int unsigned amount;
        case ($urandom_range(0, 7))
            0:       amount = 0;
            1:       amount = 1;
            2:       amount = w - 1;
            3:       amount = w;
            4:       amount = w + 1;
            5:       amount = 31;
            default: amount = $urandom_range(0, 31);
        endcase
        return ($urandom & 32'hFFFF_FFE0) | (amount & 32'h1F);
    endfunction

    // Mostly defined opcodes and widths, with a share of undefined opcodes
    // and the spare width code mixed in.
    function automatic t_in_item random_instr();
        t_in_item    instr;
        int unsigned w;
        if ($urandom_range(0, 19) == 0) begin
            instr.opcode = 4'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end else begin
            instr.opcode = 4'($urandom_range(OP_TEST, OP_SHRD));
        end
        if ($urandom_range(0, 15) == 0) begin
            instr.width_code = WIDTH_RSVD;
        end else begin
            instr.width_code = 2'($urandom_range(WIDTH_BYTE, WIDTH_DWORD));
        end
        w = width_bits(instr.width_code);
        instr.dest_value   = operand_value(w);
        instr.second_value = operand_value(w);
        if (instr.opcode inside {OP_SAR, OP_SHL, OP_SHR, OP_ROL, OP_SHLD, OP_SHRD}) begin
            instr.src_value = shift_count(w);
        end else begin
            instr.src_value = operand_value(w);
        end
        return instr;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
        fail_count++;
    endtask

    // Compares one result item against the oldest outstanding expectation.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with none outstanding", got.result, 32'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.result !== want.result)
            report_mismatch("result", got.result, want.result);
        if (got.writes_dest !== want.writes_dest)
            report_mismatch("writes_dest", 32'(got.writes_dest), 32'(want.writes_dest));
        if (got.zero_flag !== want.zero_flag)
            report_mismatch("zero_flag", 32'(got.zero_flag), 32'(want.zero_flag));
        if (got.sign_flag !== want.sign_flag)
            report_mismatch("sign_flag", 32'(got.sign_flag), 32'(want.sign_flag));
        if (got.zs_update !== want.zs_update)
            report_mismatch("zs_update", 32'(got.zs_update), 32'(want.zs_update));
        if (got.carry_flag !== want.carry_flag)
            report_mismatch("carry_flag", 32'(got.carry_flag), 32'(want.carry_flag));
        if (got.carry_update !== want.carry_update)
            report_mismatch("carry_update", 32'(got.carry_update), 32'(want.carry_update));
        if (got.overflow_flag !== want.overflow_flag)
            report_mismatch("overflow_flag", 32'(got.overflow_flag),
                            32'(want.overflow_flag));
        if (got.overflow_update !== want.overflow_update)
            report_mismatch("overflow_update", 32'(got.overflow_update),
                            32'(want.overflow_update));
    endtask

    // Offers one item, starting and ending at a falling edge. Valid is only
    // lowered when the sender actually takes a gap, so back-to-back items keep
    // it high. The expected result is queued at the edge of acceptance.
    task automatic send_item(input t_in_item instr, input logic typed_ok,
                             input t_out_item typed_want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = instr;
        do begin
            @(posedge clk);
        end while (!in_ready);
        pending_results.push_back(typed_ok ? typed_want : alu_outcome(instr));
        @(negedge clk);
    endtask

    // The sender goes quiet until the unit has returned every owed result.
    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // The receiver decides its stall for the coming edge at each falling edge.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge on which they are accepted.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_result(out_item);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Reset is held at the start and released at a falling edge.
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run under the idling of the first random phase.
        foreach (DIRECTED_ROWS[i]) begin
            send_item(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed_ok, DIRECTED_ROWS[i].want);
        end

        // Random part in three phases: a slow receiver, then a slow sender,
        // then full rate on both sides. Each phase starts from an empty unit,
        // which also gives the sender its pause until all results are back.
        for (int phase = 0; phase < 3; phase++) begin
            hold_until_drained();
            case (phase)
                0: begin
                    send_gap_pct   = 29;
                    recv_stall_pct = 58;
                end
                1: begin
                    send_gap_pct   = 58;
                    recv_stall_pct = 29;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_item(random_instr(), 1'b0, '0);
            end
        end

        // Let the last results come back, then keep watching the tail for
        // anything the unit should not produce.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
